// ----- hw/rtl/urb_pkg.sv -----
// ----------------------------------------------------------------------------
// urb_pkg
// Types, sizes and codes shared by the uart ring buffer controller modules.
// ----------------------------------------------------------------------------
package urb_pkg;

  localparam int CHANNELS = 4;
  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam int TX_PW = $clog2(TX_DEPTH);
  localparam int RX_FW = $clog2(RX_DEPTH + 1);
  localparam int TX_FW = $clog2(TX_DEPTH + 1);
  localparam int RX_AW = $clog2(CHANNELS * RX_DEPTH);
  localparam int TX_AW = $clog2(CHANNELS * TX_DEPTH);

  localparam int SIZE_W = 7;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_SIZE = 2'd1;

  localparam logic [2:0] FUNC_PUT     = 3'd0;
  localparam logic [2:0] FUNC_GET     = 3'd1;
  localparam logic [2:0] FUNC_RX_BYTE = 3'd2;
  localparam logic [2:0] FUNC_TX_DONE = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] channel;
    logic [7:0] byte_in;
    logic       frame_error;
    logic       parity_error;
  } urb_item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] read_byte;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       tx_busy;
    logic       rx_empty;
  } urb_result_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic pop_tx;
    logic pop_rx;
    logic cap_tx;
    logic cap_rx;
  } urb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;
    logic read_rx;
  } urb_stat_t;

endpackage

// ----- hw/rtl/uart_ring_buffer_controller_top.sv -----
// ----------------------------------------------------------------------------
// uart_ring_buffer_controller_top
// Multi-channel uart receive and transmit ring buffers with host commands.
// ----------------------------------------------------------------------------
// sequence: done is high in S_DONE, entered from S_EXEC, or via a read and a
//   capture state when a ring byte is read (a successful get, or a byte handed
//   to the line), the extra states set by the registered ram read port
// accept: next beat taken in the done cycle; no beat is taken while busy
// reset: pointers, fill counts and transmit flags clear, sizes go to 64; ring
//   memories keep their contents; results cannot be stalled by the receiver
module uart_ring_buffer_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  urb_pkg::urb_item_t            item,
  output logic                          done,
  output urb_pkg::urb_result_t          result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [urb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urb_pkg::SIZE_W-1:0]    cfg_data
);
  import urb_pkg::*;

  urb_cmd_t  cmd;
  urb_stat_t stat;

  assign cfg_ready = 1'b1;

  urb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  urb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // a done beat is always followed by a cycle without one
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back to back done strobes");

  // an accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not start work");

  // a byte handed to the transmitter leaves the channel busy
  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    (done && result.send_valid) |-> result.tx_busy)
    else $error("send without transmit busy");

endmodule

// ----- hw/rtl/urb_ram.sv -----
// ----------------------------------------------------------------------------
// urb_ram
// Generic simple dual port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/urb_ctrl.sv -----
// ----------------------------------------------------------------------------
// urb_ctrl
// Sequencer: accept, update pointers, optional ring read, result strobe.
// ----------------------------------------------------------------------------
module urb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output urb_pkg::urb_cmd_t cmd,
  input  urb_pkg::urb_stat_t stat
);
  import urb_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_RD_TX   = 3'd2;
  localparam logic [2:0] S_RD_RX   = 3'd3;
  localparam logic [2:0] S_DATA_TX = 3'd4;
  localparam logic [2:0] S_DATA_RX = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE) && (state != S_DONE);
  assign done = (state == S_DONE);

  always_comb begin
    cmd        = '0;
    cmd.latch  = start && !busy;
    cmd.exec   = (state == S_EXEC);
    cmd.pop_tx = (state == S_RD_TX);
    cmd.pop_rx = (state == S_RD_RX);
    cmd.cap_tx = (state == S_DATA_TX);
    cmd.cap_rx = (state == S_DATA_RX);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE, S_DONE: begin
        state_next = start ? S_EXEC : S_IDLE;
      end
      S_EXEC: begin
        if (!stat.need_read) begin
          state_next = S_DONE;
        end else if (stat.read_rx) begin
          state_next = S_RD_RX;
        end else begin
          state_next = S_RD_TX;
        end
      end
      S_RD_TX:   state_next = S_DATA_TX;
      S_RD_RX:   state_next = S_DATA_RX;
      S_DATA_TX: state_next = S_DONE;
      S_DATA_RX: state_next = S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/urb_datapath.sv -----
// ----------------------------------------------------------------------------
// urb_datapath
// Per-channel ring pointers, size registers, ring memories and result regs.
// ----------------------------------------------------------------------------
module urb_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  urb_pkg::urb_item_t          item,
  input  urb_pkg::urb_cmd_t           cmd,
  output urb_pkg::urb_stat_t          stat,
  output urb_pkg::urb_result_t        result,
  input  logic                        cfg_we,
  input  logic [urb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urb_pkg::SIZE_W-1:0]  cfg_data
);
  import urb_pkg::*;

  urb_item_t cur;

  logic [SIZE_W-1:0] rx_size;
  logic [SIZE_W-1:0] tx_size;

  logic [RX_PW-1:0] rx_write_pos [CHANNELS];
  logic [RX_PW-1:0] rx_read_pos  [CHANNELS];
  logic [RX_FW-1:0] rx_fill      [CHANNELS];
  logic [TX_PW-1:0] tx_write_pos [CHANNELS];
  logic [TX_PW-1:0] tx_read_pos  [CHANNELS];
  logic [TX_FW-1:0] tx_fill      [CHANNELS];
  logic             tx_active    [CHANNELS];

  logic             acc;
  logic             sval;
  logic [7:0]       rbyte;
  logic [7:0]       sbyte;

  logic             ch_ok;
  logic [CH_W-1:0]  ch_idx;
  logic [RX_FW-1:0] rsz;
  logic [TX_FW-1:0] tsz;
  logic [RX_PW-1:0] rxw, rxr;
  logic [TX_PW-1:0] txw, txr;
  logic [RX_FW-1:0] rxf;
  logic [TX_FW-1:0] txf;
  logic             txa;
  logic             tx_room, rx_room, put_store, rx_store_ok;
  logic [TX_FW-1:0] txf_after;
  logic             need_tx, need_rx;
  logic [RX_FW-1:0] rxw_inc, rxr_inc;
  logic [TX_FW-1:0] txw_inc, txr_inc;
  logic [RX_PW-1:0] rxw_adv, rxr_adv;
  logic [TX_PW-1:0] txw_adv, txr_adv;
  logic             rx_we, tx_we;
  logic [RX_AW-1:0] rx_waddr, rx_raddr;
  logic [TX_AW-1:0] tx_waddr, tx_raddr;
  logic [7:0]       rx_rdata, tx_rdata;

  assign ch_ok  = (32'(cur.channel) < CHANNELS);
  assign ch_idx = CH_W'(cur.channel);

  // size of zero acts as one, above the depth acts as the depth
  always_comb begin
    if (rx_size == '0) begin
      rsz = RX_FW'(1);
    end else if (32'(rx_size) > RX_DEPTH) begin
      rsz = RX_FW'(RX_DEPTH);
    end else begin
      rsz = RX_FW'(rx_size);
    end
    if (tx_size == '0) begin
      tsz = TX_FW'(1);
    end else if (32'(tx_size) > TX_DEPTH) begin
      tsz = TX_FW'(TX_DEPTH);
    end else begin
      tsz = TX_FW'(tx_size);
    end
  end

  assign rxw = rx_write_pos[ch_idx];
  assign rxr = rx_read_pos[ch_idx];
  assign rxf = rx_fill[ch_idx];
  assign txw = tx_write_pos[ch_idx];
  assign txr = tx_read_pos[ch_idx];
  assign txf = tx_fill[ch_idx];
  assign txa = tx_active[ch_idx];

  assign rxw_inc = RX_FW'(rxw) + RX_FW'(1);
  assign rxr_inc = RX_FW'(rxr) + RX_FW'(1);
  assign txw_inc = TX_FW'(txw) + TX_FW'(1);
  assign txr_inc = TX_FW'(txr) + TX_FW'(1);
  assign rxw_adv = (rxw_inc >= rsz) ? '0 : rxw_inc[RX_PW-1:0];
  assign rxr_adv = (rxr_inc >= rsz) ? '0 : rxr_inc[RX_PW-1:0];
  assign txw_adv = (txw_inc >= tsz) ? '0 : txw_inc[TX_PW-1:0];
  assign txr_adv = (txr_inc >= tsz) ? '0 : txr_inc[TX_PW-1:0];

  assign tx_room     = (txf < tsz);
  assign rx_room     = (rxf < rsz);
  assign put_store   = (cur.func == FUNC_PUT) && tx_room;
  assign rx_store_ok = (cur.func == FUNC_RX_BYTE) && !cur.frame_error &&
                       !cur.parity_error && rx_room;
  assign txf_after   = txf + TX_FW'(put_store);

  // an idle channel starts sending once its ring holds a byte
  assign need_tx = ch_ok && (((cur.func == FUNC_PUT) && !txa && (txf_after != '0)) ||
                             ((cur.func == FUNC_TX_DONE) && txa && (txf != '0)));
  assign need_rx = ch_ok && (cur.func == FUNC_GET) && (rxf != '0);

  assign stat.need_read = need_tx || need_rx;
  assign stat.read_rx   = need_rx;

  assign tx_we = cmd.exec && ch_ok && put_store;
  assign rx_we = cmd.exec && ch_ok && rx_store_ok;

  assign rx_waddr = RX_AW'(int'(ch_idx) * RX_DEPTH + int'(rxw));
  assign rx_raddr = RX_AW'(int'(ch_idx) * RX_DEPTH + int'(rxr));
  assign tx_waddr = TX_AW'(int'(ch_idx) * TX_DEPTH + int'(txw));
  assign tx_raddr = TX_AW'(int'(ch_idx) * TX_DEPTH + int'(txr));

  urb_ram #(.WIDTH(8), .DEPTH(CHANNELS * RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (cur.byte_in),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  urb_ram #(.WIDTH(8), .DEPTH(CHANNELS * TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (cur.byte_in),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_size <= SIZE_RESET;
      tx_size <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RX_SIZE) begin
        rx_size <= cfg_data;
      end else if (cfg_index == CFG_TX_SIZE) begin
        tx_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rx_write_pos[i] <= '0;
        rx_read_pos[i]  <= '0;
        rx_fill[i]      <= '0;
        tx_write_pos[i] <= '0;
        tx_read_pos[i]  <= '0;
        tx_fill[i]      <= '0;
        tx_active[i]    <= 1'b0;
      end
    end else if (cmd.exec && ch_ok) begin
      case (cur.func)
        FUNC_PUT: begin
          if (put_store) begin
            tx_write_pos[ch_idx] <= txw_adv;
            tx_fill[ch_idx]      <= txf + TX_FW'(1);
          end
        end
        FUNC_RX_BYTE: begin
          if (rx_store_ok) begin
            rx_write_pos[ch_idx] <= rxw_adv;
            rx_fill[ch_idx]      <= rxf + RX_FW'(1);
          end
        end
        FUNC_TX_DONE: begin
          if (txa && (txf == '0)) begin
            tx_active[ch_idx] <= 1'b0;
          end
        end
        FUNC_CLEAR: begin
          rx_write_pos[ch_idx] <= '0;
          rx_read_pos[ch_idx]  <= '0;
          rx_fill[ch_idx]      <= '0;
          tx_write_pos[ch_idx] <= '0;
          tx_read_pos[ch_idx]  <= '0;
          tx_fill[ch_idx]      <= '0;
          tx_active[ch_idx]    <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (cmd.pop_tx) begin
      tx_read_pos[ch_idx] <= txr_adv;
      tx_fill[ch_idx]     <= txf - TX_FW'(1);
      tx_active[ch_idx]   <= 1'b1;
    end else if (cmd.pop_rx) begin
      rx_read_pos[ch_idx] <= rxr_adv;
      rx_fill[ch_idx]     <= rxf - RX_FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc   <= ch_ok && (put_store || need_rx);
      sval  <= need_tx;
      rbyte <= '0;
      sbyte <= '0;
    end else if (cmd.cap_tx) begin
      sbyte <= tx_rdata;
    end else if (cmd.cap_rx) begin
      rbyte <= rx_rdata;
    end
  end

  always_comb begin
    result.accepted   = acc;
    result.read_byte  = rbyte;
    result.send_valid = sval;
    result.send_byte  = sbyte;
    result.tx_busy    = ch_ok && txa;
    result.rx_empty   = !ch_ok || (rxf == '0);
  end

endmodule
